[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GHE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ghe assertion failed");

// next-cycle implication
`define GHE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ghe assertion failed");

`else

`define GHE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define GHE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/ghe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ghe_pkg;

   localparam int BINS       = 256;
   localparam int COUNT_BITS = 23;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int PIX_BITS   = 8;
   localparam int LEVEL_BITS = 9;
   localparam int PROD_BITS  = COUNT_BITS + PIX_BITS;
   localparam int DIV_STEPS  = PIX_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0]  CNT_MAX      = {COUNT_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0]  LEVELS_RESET = LEVEL_BITS'(BINS);

   // register index, taken from paddr above the byte offset
   localparam logic [ADDR_BITS-3:0] REG_LEVELS = '0;

   // pass selector codes
   localparam logic FUNC_COUNT = 1'b0;
   localparam logic FUNC_MAP   = 1'b1;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic                func;
      logic                last_of_pass;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] mapped_pixel;
      logic                out_last;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic bin_wr;
      logic bld_init;
      logic bld_rd;
      logic bld_acc;
      logic bld_mul;
      logic div_step;
      logic tbl_wr;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic item_func;
      logic item_last;
      logic idx_last;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/ghe_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/ghe_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ghe_datapath
   import ghe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire req_type               req_data,
   input  wire logic [LEVEL_BITS-1:0] levels,
   output status_type                 status,
   output rsp_type                    rsp_data
);

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + COUNT_BITS'(1);
   endfunction

   logic [PIX_BITS-1:0]   lm1;
   logic [PIX_BITS-1:0]   pix_sat;
   logic [BIN_BITS-1:0]   pix_ff, pix_in;
   logic                  func_ff, func_in;
   logic                  last_ff, last_in;
   logic [BIN_BITS-1:0]   bin_idx_ff, bin_idx_in;
   logic [BINS-1:0]       bin_valid_ff, bin_valid_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] running_sum_ff, running_sum_in;
   logic [PROD_BITS-1:0]  rem_ff, rem_in;
   logic [PIX_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   logic [BIN_BITS-1:0]   bin_rd_addr;
   logic [COUNT_BITS-1:0] bin_rdata;
   logic [COUNT_BITS-1:0] bin_count;
   logic [COUNT_BITS:0]   sum_wide;
   logic [COUNT_BITS-1:0] sum_sat;
   logic [COUNT_BITS-1:0] cdf;
   logic [PROD_BITS-1:0]  product;
   logic [PROD_BITS-1:0]  trial;
   logic                  div_ge;
   logic [PIX_BITS-1:0]   tbl_rdata;

   // clamp levels to 2..BINS, keep levels minus one
   always_comb begin
      if (levels < LEVEL_BITS'(2)) begin
         lm1 = PIX_BITS'(1);
      end else if (levels > LEVEL_BITS'(BINS)) begin
         lm1 = PIX_BITS'(BINS - 1);
      end else begin
         lm1 = PIX_BITS'(levels - LEVEL_BITS'(1));
      end
   end

   assign pix_sat = (req_data.pixel > lm1) ? lm1 : req_data.pixel;

   assign bin_rd_addr = cmd.bld_rd ? bin_idx_ff : pix_ff;
   assign bin_count   = rd_valid_ff ? bin_rdata : '0;
   assign sum_wide    = {1'b0, running_sum_ff} + {1'b0, bin_count};
   assign sum_sat     = sum_wide[COUNT_BITS] ? CNT_MAX : sum_wide[COUNT_BITS-1:0];
   assign cdf         = (running_sum_ff > total_ff) ? total_ff : running_sum_ff;
   assign product     = PROD_BITS'(cdf) * PROD_BITS'(lm1);
   assign trial       = PROD_BITS'(total_ff) << step_ff;
   assign div_ge      = rem_ff >= trial;

   always_comb begin
      pix_in         = cmd.load_item ? BIN_BITS'(pix_sat) : pix_ff;
      func_in        = cmd.load_item ? req_data.func : func_ff;
      last_in        = cmd.load_item ? req_data.last_of_pass : last_ff;
      rd_valid_in    = bin_valid_ff[bin_rd_addr];
      bin_valid_in   = bin_valid_ff;
      total_in       = total_ff;
      running_sum_in = running_sum_ff;
      bin_idx_in     = bin_idx_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;

      if (cmd.bin_wr) begin
         bin_valid_in[pix_ff] = 1'b1;
         total_in             = sat_inc(total_ff);
      end
      if (cmd.bld_init) begin
         running_sum_in = '0;
         bin_idx_in     = '0;
      end
      if (cmd.bld_acc) begin
         running_sum_in = sum_sat;
      end
      if (cmd.bld_mul) begin
         rem_in  = product;
         quo_in  = '0;
         step_in = STEP_BITS'(DIV_STEPS - 1);
      end
      if (cmd.div_step) begin
         rem_in  = div_ge ? rem_ff - trial : rem_ff;
         quo_in  = {quo_ff[PIX_BITS-2:0], div_ge};
         step_in = step_ff - STEP_BITS'(1);
      end
      if (cmd.tbl_wr) begin
         bin_idx_in = bin_idx_ff + BIN_BITS'(1);
      end
      if (cmd.clear) begin
         bin_valid_in   = '0;
         total_in       = '0;
         running_sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff   <= '0;
         total_ff       <= '0;
         running_sum_ff <= '0;
      end else begin
         bin_valid_ff   <= bin_valid_in;
         total_ff       <= total_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      func_ff     <= func_in;
      last_ff     <= last_in;
      rd_valid_ff <= rd_valid_in;
      bin_idx_ff  <= bin_idx_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
   end

   ghe_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (cmd.bin_wr),
      .wr_addr (pix_ff),
      .wr_data (sat_inc(bin_count)),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rdata)
   );

   ghe_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (BINS)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (cmd.tbl_wr),
      .wr_addr (bin_idx_ff),
      .wr_data (quo_ff),
      .rd_addr (pix_ff),
      .rd_data (tbl_rdata)
   );

   assign status.item_func = func_ff;
   assign status.item_last = last_ff;
   assign status.idx_last  = bin_idx_ff == BIN_BITS'(BINS - 1);
   assign status.div_last  = step_ff == '0;

   assign rsp_data.mapped_pixel = tbl_rdata;
   assign rsp_data.out_last     = last_ff;

   `GHE_ASSERT_NEXT(a_clear_bins, clock, reset, cmd.clear, bin_valid_ff == '0)
   `GHE_ASSERT_IMPL(a_quot_range, clock, reset, cmd.tbl_wr, quo_ff <= lm1)
   `GHE_ASSERT_IMPL(a_total_set, clock, reset, cmd.bld_mul, total_ff != '0)

endmodule

`default_nettype wire

[hw/rtl/ghe_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ghe_ctrl
   import ghe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output logic            rsp_strobe,
   output cmd_type         cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_READ    = 9'b000000010,
      ST_CNT_WR  = 9'b000000100,
      ST_MAP_OUT = 9'b000001000,
      ST_BLD_RD  = 9'b000010000,
      ST_BLD_ACC = 9'b000100000,
      ST_BLD_MUL = 9'b001000000,
      ST_BLD_DIV = 9'b010000000,
      ST_BLD_WR  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (status.item_func == FUNC_MAP) ? ST_MAP_OUT : ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.bin_wr = 1'b1;
            if (status.item_last) begin
               cmd.bld_init = 1'b1;
               state_in     = ST_BLD_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAP_OUT: begin
            cmd.clear = status.item_last;
            state_in  = ST_IDLE;
         end
         ST_BLD_RD: begin
            cmd.bld_rd = 1'b1;
            state_in   = ST_BLD_ACC;
         end
         ST_BLD_ACC: begin
            cmd.bld_acc = 1'b1;
            state_in    = ST_BLD_MUL;
         end
         ST_BLD_MUL: begin
            cmd.bld_mul = 1'b1;
            state_in    = ST_BLD_DIV;
         end
         ST_BLD_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_BLD_WR;
            end
         end
         ST_BLD_WR: begin
            cmd.tbl_wr = 1'b1;
            state_in   = status.idx_last ? ST_IDLE : ST_BLD_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = state_ff == ST_MAP_OUT;

   `GHE_ASSERT_NEXT(a_accept_moves, clock, reset, start && (state_ff == ST_IDLE), state_ff == ST_READ)
   `GHE_ASSERT_IMPL(a_out_after_read, clock, reset, state_ff == ST_MAP_OUT, $past(state_ff) == ST_READ)
   `GHE_ASSERT_NEXT(a_build_ends, clock, reset, (state_ff == ST_BLD_WR) && status.idx_last, state_ff == ST_IDLE)

endmodule

`default_nettype wire

[hw/rtl/global_histogram_equalizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                  accepted when
// -------   ------------------------------------   -----------------------------------
// input     start, busy, req_data                  start high and busy low
// result    rsp_strobe, rsp_data                   every cycle rsp_strobe is high
// config    psel penable pwrite paddr pwdata       psel, penable, pwrite, pready high
//           prdata pready
//
// a count-pass word goes through accept, bin read and bin write; a map-pass word
// goes through accept, table read and output; rsp_strobe is high in the output state
// the last count-pass word starts the table build: each bin goes through bin read,
// sum, multiply, 8 divide steps and table write, for all 256 bins, busy held
// the build time is set by the one-bit-a-cycle divider shared by all bins
// reset clears the fsm, the pixel total, the cdf sum and the bin valid flags at once,
// so there is no clearing sweep; levels resets to 256
// the receiver cannot stall: each result is strobed for one cycle only

module global_histogram_equalizer
   import ghe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // pixel words
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   // mapped results
   output logic                      rsp_strobe,
   output rsp_type                   rsp_data,
   // register port
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready
);

   logic [LEVEL_BITS-1:0] levels_ff, levels_in;
   logic                  reg_hit;
   cmd_type               cmd;
   status_type            status;

   // register decode: word index sits above the byte offset
   assign reg_hit = paddr[ADDR_BITS-1:2] == REG_LEVELS;

   // levels register, written in the apb access phase
   assign levels_in = (psel && penable && pwrite && reg_hit) ? pwdata[LEVEL_BITS-1:0]
                                                             : levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   // readback, unused addresses read as zero
   assign prdata = reg_hit ? DATA_BITS'(levels_ff) : '0;
   assign pready = 1'b1;

   // sequencer: accepts words, walks the table build
   ghe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // histogram, cdf, divider and mapping table
   ghe_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .levels   (levels_ff),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[bench/global_histogram_equalizer_test.sv]
`timescale 1ns / 1ps

import ghe_pkg::*;

// mirror of the equalizer state, one expected result per map-pass word
class equalizer_scoreboard;
   logic [LEVEL_BITS-1:0] levels_reg;
   logic [COUNT_BITS-1:0] bin_hist [BINS];
   logic [PIX_BITS-1:0]   gray_map [BINS];
   logic [COUNT_BITS-1:0] pix_count;
   logic [COUNT_BITS-1:0] cdf_sum;
   rsp_type               mapped_q [$];
   int                    mismatches;

   function new();
      levels_reg = LEVELS_RESET;
      mismatches = 0;
      clear_hist();
      foreach (gray_map[i]) gray_map[i] = '0;
   endfunction

   function void clear_hist();
      foreach (bin_hist[i]) bin_hist[i] = '0;
      pix_count = '0;
      cdf_sum   = '0;
   endfunction

   function void set_levels(input logic [LEVEL_BITS-1:0] value);
      levels_reg = value;
   endfunction

   function int unsigned eff_levels();
      int unsigned l;
      l = levels_reg;
      if (l < 2) l = 2;
      if (l > BINS) l = BINS;
      return l;
   endfunction

   function logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function void build_map(input int unsigned l);
      longint unsigned sum;
      longint unsigned cdf;
      sum = 0;
      for (int i = 0; i < BINS; i++) begin
         sum += bin_hist[i];
         if (sum > CNT_MAX) sum = CNT_MAX;
         cdf = (sum > pix_count) ? pix_count : sum;
         if (pix_count == 0)
            gray_map[i] = '0;
         else
            gray_map[i] = PIX_BITS'((cdf * (l - 1)) / pix_count);
      end
      cdf_sum = COUNT_BITS'(sum);
   endfunction

   function void note_word(input req_type w);
      int unsigned l;
      int unsigned pix;
      rsp_type     r;
      l   = eff_levels();
      pix = w.pixel;
      if (pix > l - 1) pix = l - 1;
      if (w.func == FUNC_COUNT) begin
         bin_hist[pix] = sat_inc(bin_hist[pix]);
         pix_count     = sat_inc(pix_count);
         if (w.last_of_pass) build_map(l);
      end else begin
         r.mapped_pixel = gray_map[pix];
         r.out_last     = w.last_of_pass;
         mapped_q.push_back(r);
         if (w.last_of_pass) clear_hist();
      end
   endfunction

   function void report(input string what, input int unsigned want, input int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endfunction

   function void check_result(input rsp_type got);
      rsp_type want;
      if (mapped_q.size() == 0) begin
         report("unexpected result, mapped_pixel", 0, got.mapped_pixel);
         return;
      end
      want = mapped_q.pop_front();
      if (got.mapped_pixel !== want.mapped_pixel)
         report("mapped_pixel", want.mapped_pixel, got.mapped_pixel);
      if (got.out_last !== want.out_last)
         report("out_last", want.out_last, got.out_last);
   endfunction

   function int pending();
      return mapped_q.size();
   endfunction
endclass

module global_histogram_equalizer_test;

   // a table build walks every bin; the wait covers it plus slack
   localparam int BUILD_WAIT  = 12 * BINS + 40;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_WORDS = 500;
   localparam logic [ADDR_BITS-1:0] LEVELS_ADDR = {REG_LEVELS, 2'b00};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   equalizer_scoreboard sb;
   int                  idle_pct;
   int                  words_sent;
   int                  cycle_count;

   global_histogram_equalizer uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run guard: a hung block ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // results cannot be held off, so every strobe is checked on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   // one pixel word: optional idle gap, then start held until busy is seen low
   // start is left high and is only lowered at a falling edge by a later idle gap, levels
   // write or results wait, so back-to-back words keep it high without a glitch
   task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic func,
                             input logic last);
      req_type w;
      int      gap;
      w.pixel        = pix;
      w.func         = func;
      w.last_of_pass = last;
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      sb.note_word(w);
      words_sent++;
   endtask

   // apb write of levels: setup cycle, then access cycle until pready
   task automatic write_levels(input logic [DATA_BITS-1:0] value);
      @(negedge clock);
      start   <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LEVELS_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_levels(value[LEVEL_BITS-1:0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // stop sending and wait until every mapped word has come back
   task automatic wait_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // full quiet point: results drained and any table build given time to finish
   task automatic settle();
      wait_results();
      repeat (BUILD_WAIT) @(posedge clock);
   endtask

   // pixel value shapes: uniform, low cluster, around the saturation point, extremes
   function automatic logic [PIX_BITS-1:0] pick_pixel(input int mode, input int unsigned lv);
      int unsigned lo;
      lo = (lv >= 2) ? lv - 2 : 0;
      case (mode)
         0: return PIX_BITS'($urandom_range(0, 255));
         1: return PIX_BITS'($urandom_range(0, 7) * 3);
         2: return PIX_BITS'($urandom_range(lo, 255));
         default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // one random frame, mostly well formed
   // kind 1: second count pass, kind 2: levels change between passes,
   // kind 7: count pass with no last word, kind 8: map pass with no last word,
   // kind 9: loose words with random pass and last flags
   task automatic run_frame();
      int kind;
      int n;
      int m;
      int mode;
      kind = $urandom_range(0, 9);
      n    = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         send_pixel(pick_pixel(mode, sb.eff_levels()), FUNC_COUNT, (i == n - 1) && kind != 7);
      if (kind == 1) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            send_pixel(pick_pixel(0, sb.eff_levels()), FUNC_COUNT, i == n - 1);
      end
      if (kind == 2) begin
         settle();
         write_levels($urandom_range(0, 511));
      end
      m    = $urandom_range(1, 60);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < m; i++)
         send_pixel(pick_pixel(mode, sb.eff_levels()), FUNC_MAP, (i == m - 1) && kind != 8);
      if (kind == 9) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int idle_plan [4];
      int target;
      idle_plan = '{0, 66, 0, 19};

      sb          = new();
      idle_pct    = 0;
      words_sent  = 0;
      cycle_count = 0;

      // every input known from time zero
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset levels, full range, extremes and a repeated value
      send_pixel(8'd0,   FUNC_COUNT, 1'b0);
      send_pixel(8'd255, FUNC_COUNT, 1'b0);
      send_pixel(8'd128, FUNC_COUNT, 1'b0);
      send_pixel(8'd0,   FUNC_COUNT, 1'b1);
      send_pixel(8'd0,   FUNC_MAP,   1'b0);
      send_pixel(8'd255, FUNC_MAP,   1'b0);
      send_pixel(8'd128, FUNC_MAP,   1'b0);
      send_pixel(8'd9,   FUNC_MAP,   1'b1);

      // two levels, pixels above saturate; levels all ones before the map pass
      // clamps to the bin count while the table keeps its two-level mapping
      settle();
      write_levels(32'd2);
      send_pixel(8'd0,   FUNC_COUNT, 1'b0);
      send_pixel(8'd1,   FUNC_COUNT, 1'b0);
      send_pixel(8'd200, FUNC_COUNT, 1'b1);
      settle();
      write_levels(32'd511);
      send_pixel(8'd0,   FUNC_MAP,   1'b0);
      send_pixel(8'd1,   FUNC_MAP,   1'b0);
      send_pixel(8'd255, FUNC_MAP,   1'b1);

      // levels zero clamps up to two; single-pixel frame
      settle();
      write_levels(32'd0);
      send_pixel(8'd5,   FUNC_COUNT, 1'b1);
      send_pixel(8'd5,   FUNC_MAP,   1'b0);
      send_pixel(8'd0,   FUNC_MAP,   1'b1);

      // repeated count passes keep accumulating; sender pauses mid map pass
      settle();
      write_levels(32'd100);
      send_pixel(8'd99,  FUNC_COUNT, 1'b0);
      send_pixel(8'd150, FUNC_COUNT, 1'b1);
      send_pixel(8'd3,   FUNC_COUNT, 1'b1);
      send_pixel(8'd99,  FUNC_MAP,   1'b0);
      wait_results();
      send_pixel(8'd3,   FUNC_MAP,   1'b0);
      send_pixel(8'd150, FUNC_MAP,   1'b1);

      // random phases, each with its own levels and idle rate
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: write_levels(32'd2);
            1: write_levels(32'd256);
            2: write_levels($urandom_range(3, 255));
            default: write_levels($urandom_range(0, 511));
         endcase
         idle_pct = idle_plan[ph];
         target   = words_sent + PHASE_WORDS;
         while (words_sent < target) run_frame();
      end

      // drain and let any trailing build finish
      settle();
      if (sb.pending() != 0)
         $display("results never seen: %0d", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ghe_pkg.sv
hw/rtl/ghe_ram.sv
hw/rtl/ghe_datapath.sv
hw/rtl/ghe_ctrl.sv
hw/rtl/global_histogram_equalizer.sv
bench/global_histogram_equalizer_test.sv
